FILE: rtl/sha256_byte_stream_hasher_defines.svh
// Assertion macros for the SHA-256 byte stream hasher checker.
// No dependencies.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Implication that must hold at every clock edge outside reset.
`define SHA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sha256 check failed");

// Implication checked in the cycle after the antecedent.
`define SHA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sha256 check failed");

`endif

FILE: rtl/sha_pkg.sv
// Package: SHA-256 constants, types and message schedule functions.
// No dependencies.
package sha_pkg;

    localparam int BlockBytes = 64;
    localparam int LenOffset = 56;
    localparam logic [7:0] PadByte = 8'h80;
    localparam int QueueDepth = 4;

    typedef logic [31:0] word_t;
    typedef logic [5:0] pos_t;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        BLK_RAW,
        BLK_PAD_LEN,
        BLK_PAD_ONLY,
        BLK_LEN_ONLY
    } blk_t;

    localparam word_t IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam word_t K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic word_t ror(input word_t v, input int k);
        return (v >> k) | (v << (32 - k));
    endfunction

    function automatic word_t sig0(input word_t x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t sig1(input word_t x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Depends on sha_pkg, sha_front and sha_back.
// Requests enter a four-entry queue at one a cycle while it has room; the core takes one a cycle while idle.
// A block passes through load, 64 rounds and add; 64 bytes need a second block for padding and length.
// The first digest word follows the closing request after load, rounds and add, repeated for two blocks.
// aresetn (synchronous, active low) restores the initial hash and empties the queue.
module sha256_byte_stream_hasher import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tuser,   // byte_valid
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // digest_word
    output logic [1:0]  m_tuser,   // word_index
    output logic        m_tlast    // last_word
);

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item = '{data: s_tdata, byte_valid: s_tuser, last: s_tlast};

    sha_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item));

    sha_back u_back (
        .aclk, .aresetn,
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .m_valid(m_tvalid), .m_ready(m_tready), .m_word(m_tdata),
        .m_index(m_tuser), .m_last(m_tlast));

endmodule

FILE: rtl/sha_front.sv
// Front end: register input bytes into a short queue of tagged items.
// Depends on sha_pkg.
module sha_front import sha_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int PtrW = $clog2(QueueDepth);

    item_t           mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [PtrW:0]   cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready  = (cnt_reg != (PtrW+1)'(QueueDepth));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/sha_back.sv
// Back end: block assembly, padding, one-round-per-cycle compression, digest out.
// Depends on sha_pkg.
module sha_back import sha_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_word,
    output logic [1:0]  m_index,
    output logic        m_last
);

    state_t      state_reg, state_next;
    blk_t        kind_reg;
    word_t       h_reg [8];
    word_t       r_reg [8];
    word_t       w_reg [16];
    logic [63:0] cnt_reg;
    logic [63:0] cnt_inc;
    logic [63:0] bits_reg;
    pos_t        pos_reg;
    logic [5:0]  round_reg;
    logic        final_reg;
    logic [1:0]  emit_reg;

    word_t t1, t2, wnew, big0, big1, ch, mj;
    logic  take, blk_full;
    pos_t  cur_pos;

    assign cur_pos  = cnt_reg[5:0];
    assign cnt_inc  = cnt_reg + 64'(in_item.byte_valid);
    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid && in_ready;
    assign blk_full = in_item.byte_valid && (cur_pos == 6'd63);

    assign big1 = ror(r_reg[4], 6) ^ ror(r_reg[4], 11) ^ ror(r_reg[4], 25);
    assign ch   = (r_reg[4] & r_reg[5]) ^ (~r_reg[4] & r_reg[6]);
    assign big0 = ror(r_reg[0], 2) ^ ror(r_reg[0], 13) ^ ror(r_reg[0], 22);
    assign mj   = (r_reg[0] & r_reg[1]) ^ (r_reg[0] & r_reg[2]) ^ (r_reg[1] & r_reg[2]);
    assign t1   = r_reg[7] + big1 + ch + K[round_reg] + w_reg[0];
    assign t2   = big0 + mj;
    assign wnew = w_reg[0] + sig0(w_reg[1]) + w_reg[9] + sig1(w_reg[14]);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && (blk_full || in_item.last)) state_next = ST_PAD;
            end
            ST_PAD:  state_next = ST_COMP;
            ST_COMP: if (round_reg == 6'd63) state_next = ST_ADD;
            ST_ADD: begin
                if (!final_reg) state_next = ST_IDLE;
                else if (kind_reg inside {BLK_RAW, BLK_PAD_ONLY}) state_next = ST_PAD;
                else state_next = ST_EMIT;
            end
            ST_EMIT: if (m_ready && emit_reg == 2'd3) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid = (state_reg == ST_EMIT);
        m_index = emit_reg;
        m_last  = (emit_reg == 2'd3);
        m_word  = {h_reg[{emit_reg, 1'b0}], h_reg[{emit_reg, 1'b1}]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= BLK_RAW;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
            emit_reg  <= '0;
            round_reg <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
        end else begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        cnt_reg   <= cnt_inc;
                        bits_reg  <= {cnt_inc[60:0], 3'b000};
                        pos_reg   <= cnt_inc[5:0];
                        final_reg <= in_item.last;
                        if (blk_full) kind_reg <= BLK_RAW;
                        else if (cnt_inc[5:0] >= 6'(LenOffset)) kind_reg <= BLK_PAD_ONLY;
                        else kind_reg <= BLK_PAD_LEN;
                    end
                end
                ST_PAD: round_reg <= '0;
                ST_COMP: round_reg <= round_reg + 1'b1;
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + r_reg[i];
                    if (kind_reg == BLK_RAW) kind_reg <= BLK_PAD_LEN;
                    else if (kind_reg == BLK_PAD_ONLY) kind_reg <= BLK_LEN_ONLY;
                    emit_reg <= '0;
                end
                ST_EMIT: begin
                    if (m_ready) begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg == 2'd3) begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= IV[i];
                            cnt_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Byte i of the block presented to the schedule.
    function automatic logic [7:0] pad_byte(input pos_t i, input logic [7:0] b);
        logic [7:0] v;
        v = 8'h00;
        case (kind_reg)
            BLK_RAW: v = b;
            BLK_PAD_LEN, BLK_PAD_ONLY: begin
                if (i < pos_reg) v = b;
                else if (i == pos_reg) v = PadByte;
                else if (kind_reg == BLK_PAD_LEN && i >= 6'(LenOffset))
                    v = bits_reg[{~i[2:0], 3'b000} +: 8];
            end
            BLK_LEN_ONLY: begin
                if (i >= 6'(LenOffset)) v = bits_reg[{~i[2:0], 3'b000} +: 8];
            end
            default: v = b;
        endcase
        return v;
    endfunction

    always_ff @(posedge aclk) begin
        if (take && in_item.byte_valid) begin
            w_reg[cur_pos[5:2]][{~cur_pos[1:0], 3'b000} +: 8] <= in_item.data;
        end else if (state_reg == ST_PAD) begin
            for (int i = 0; i < BlockBytes; i++) begin
                w_reg[i/4][8*(3-(i%4)) +: 8] <= pad_byte(6'(i), w_reg[i/4][8*(3-(i%4)) +: 8]);
            end
            for (int i = 0; i < 8; i++) r_reg[i] <= h_reg[i];
        end else if (state_reg == ST_COMP) begin
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= wnew;
            r_reg[7] <= r_reg[6];
            r_reg[6] <= r_reg[5];
            r_reg[5] <= r_reg[4];
            r_reg[4] <= r_reg[3] + t1;
            r_reg[3] <= r_reg[2];
            r_reg[2] <= r_reg[1];
            r_reg[1] <= r_reg[0];
            r_reg[0] <= t1 + t2;
        end
    end

endmodule

FILE: rtl/sha_checker.sv
// Port checker for the SHA-256 byte stream hasher, bound to the top level.
// Depends on sha256_byte_stream_hasher_defines.svh.
`include "sha256_byte_stream_hasher_defines.svh"
module sha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);
    `SHA_ASSERT_IMPL(a_last_idx, m_tvalid, m_tlast == (m_tuser == 2'd3))
    `SHA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SHA_ASSERT_NEXT(a_step, m_tvalid && m_tready && !m_tlast,
                     m_tvalid && m_tuser == $past(m_tuser) + 2'd1)
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (.*);
